/* design/vgm_wait_and_write_encoder_macros.svh */
// ---------------------------------------------------------------------------
// VGM wait-and-write encoder assertion macros
// Concurrent assertion wrappers shared by the encoder modules. Defining
// ASSERT_OFF turns every use into nothing.
// ---------------------------------------------------------------------------
`ifndef VGM_WAIT_AND_WRITE_ENCODER_MACROS_SVH
`define VGM_WAIT_AND_WRITE_ENCODER_MACROS_SVH

`ifndef ASSERT_OFF

// Property must hold at every clock edge outside reset.
`define VGM_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Expression must never be true at a clock edge outside reset.
`define VGM_ASSERT_NEVER(lbl, clk, rst, expr, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

`else

`define VGM_ASSERT(lbl, clk, rst, prop, msg)
`define VGM_ASSERT_NEVER(lbl, clk, rst, expr, msg)

`endif

`endif

/* design/vgm_enc_pkg.sv */
// ---------------------------------------------------------------------------
// VGM encoder package
// Command bytes, wait constants, state and byte select codes, and the
// command and status bundles between the controller and the datapath.
// ---------------------------------------------------------------------------
`default_nettype none

package vgm_enc_pkg;

   // Stream command bytes.
   localparam logic [7:0] OP_WAIT_NTSC = 8'h62;
   localparam logic [7:0] OP_WAIT_PAL  = 8'h63;
   localparam logic [7:0] OP_WAIT_N    = 8'h61;
   localparam logic [7:0] OP_WRITE     = 8'h41;
   localparam logic [7:0] OP_END       = 8'h66;
   localparam logic [7:0] BYTE_FULL    = 8'hFF;

   // Wait lengths in samples.
   localparam int FRAME_SAMPLES = 735;
   localparam int PAL_SAMPLES   = 882;
   localparam int CHUNK_SAMPLES = 65535;

   // Narrowest wait register that still holds every compare constant.
   localparam int WAIT_MIN_W = $clog2(CHUNK_SAMPLES + 2 * PAL_SAMPLES + 1);

   // Bytes kept per input beat, and the counter that tracks them.
   localparam int RESULT_LIMIT = 12;
   localparam int CNT_W        = $clog2(RESULT_LIMIT + 1);

   localparam int MAX_GAP_DEFAULT = 255;

   // Controller states.
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL,
      ST_DECIDE,
      ST_PRE0,
      ST_PRE1,
      ST_LONG_OP,
      ST_LONG_LO,
      ST_LONG_HI,
      ST_CMD,
      ST_ADDR,
      ST_DATA,
      ST_END_A,
      ST_END_B
   } enc_state_type;

   // Source of the byte loaded into the output register.
   typedef enum logic [3:0] {
      SEL_PRE0,
      SEL_PRE1,
      SEL_LONG_OP,
      SEL_LONG_LO,
      SEL_LONG_HI,
      SEL_WRITE_OP,
      SEL_ADDR,
      SEL_DATA,
      SEL_END_WAIT,
      SEL_END_OP
   } byte_sel_type;

   // Controller to datapath.
   typedef struct packed {
      logic         load;
      logic         mul;
      logic         decide;
      logic         emit;
      byte_sel_type sel;
      logic         last;
   } enc_cmd_type;

   // Datapath to controller.
   typedef struct packed {
      logic       out_free;
      logic       wait_zero;
      logic [1:0] cls_pre_n;
      logic [1:0] pre_n;
      logic       has_long;
      logic       cnt_last;
   } enc_sts_type;

endpackage

`default_nettype wire

/* design/vgm_enc_dp.sv */
// ---------------------------------------------------------------------------
// VGM encoder datapath
// Holds the current frame, the pending wait in samples, the wait plan of
// the current command, the byte counter and the output register.
// ---------------------------------------------------------------------------
`default_nettype none
`include "vgm_wait_and_write_encoder_macros.svh"

module vgm_enc_dp #(
   parameter int MAX_GAP = vgm_enc_pkg::MAX_GAP_DEFAULT
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic [31:0]              req_write_frame,
   input  wire logic [7:0]               req_reg_addr,
   input  wire logic [7:0]               req_reg_data,
   input  wire logic                     req_type,
   input  wire vgm_enc_pkg::enc_cmd_type cmd,
   output      vgm_enc_pkg::enc_sts_type sts,
   input  wire logic                     rsp_stall,
   output      logic                     rsp_valid,
   output      logic [7:0]               rsp_out_byte,
   output      logic                     rsp_last,
   output      logic                     rsp_gap_clamped
);
   import vgm_enc_pkg::*;

   localparam int GAP_W    = $clog2(MAX_GAP + 1);
   localparam int WAIT_RAW = $clog2(MAX_GAP * FRAME_SAMPLES + 1);
   localparam int WAIT_W   = (WAIT_RAW > WAIT_MIN_W) ? WAIT_RAW : WAIT_MIN_W;

   logic [31:0]       cur_frame_ff, cur_frame_in;
   logic [GAP_W-1:0]  gap_ff, gap_in;
   logic              clamp_ff, clamp_in;
   logic [7:0]        addr_ff, data_ff;
   logic [WAIT_W-1:0] w_ff, w_in;
   logic [7:0]        pre0_ff, pre1_ff, pre0_c, pre1_c;
   logic [1:0]        pre_n_ff, pre_n_c;
   logic              has_long_ff, has_long_c;
   logic [15:0]       long_ff, long_c;
   logic [WAIT_W-1:0] w_next_c;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [7:0]        byte_ff, byte_in;
   logic              last_ff, clamped_ff;
   logic [32:0]       diff;
   logic              advance, over;

   // Frame gap: borrow of the subtraction tells whether the frame advanced.
   assign diff    = {1'b0, req_write_frame} - {1'b0, cur_frame_ff};
   assign advance = !diff[32] && (diff[31:0] != 32'd0);
   assign over    = advance && (diff[31:0] > 32'(MAX_GAP));

   always_comb begin
      cur_frame_in = cur_frame_ff;
      gap_in       = gap_ff;
      clamp_in     = clamp_ff;
      if (cmd.load) begin
         if (req_type) begin
            gap_in   = '0;
            clamp_in = 1'b0;
         end else begin
            if (advance) begin
               cur_frame_in = req_write_frame;
            end
            gap_in   = !advance ? '0 : (over ? GAP_W'(MAX_GAP) : diff[GAP_W-1:0]);
            clamp_in = over;
         end
      end
   end

   // Wait plan for the pending samples: short prefixes and/or a long wait.
   always_comb begin
      pre0_c     = OP_WAIT_NTSC;
      pre1_c     = OP_WAIT_NTSC;
      pre_n_c    = 2'd0;
      has_long_c = 1'b1;
      long_c     = w_ff[15:0];
      w_next_c   = '0;
      if (w_ff == WAIT_W'(FRAME_SAMPLES)) begin
         pre_n_c    = 2'd1;
         has_long_c = 1'b0;
      end else if (w_ff == WAIT_W'(PAL_SAMPLES)) begin
         pre0_c     = OP_WAIT_PAL;
         pre_n_c    = 2'd1;
         has_long_c = 1'b0;
      end else if (w_ff == WAIT_W'(2 * FRAME_SAMPLES)) begin
         pre_n_c    = 2'd2;
         has_long_c = 1'b0;
      end else if (w_ff == WAIT_W'(2 * PAL_SAMPLES)) begin
         pre0_c     = OP_WAIT_PAL;
         pre1_c     = OP_WAIT_PAL;
         pre_n_c    = 2'd2;
         has_long_c = 1'b0;
      end else if (w_ff == WAIT_W'(FRAME_SAMPLES + PAL_SAMPLES)) begin
         pre1_c     = OP_WAIT_PAL;
         pre_n_c    = 2'd2;
         has_long_c = 1'b0;
      end else if (w_ff <= WAIT_W'(CHUNK_SAMPLES)) begin
         long_c = w_ff[15:0];
      end else if (w_ff <= WAIT_W'(CHUNK_SAMPLES + PAL_SAMPLES)) begin
         pre0_c  = OP_WAIT_PAL;
         pre_n_c = 2'd1;
         long_c  = w_ff[15:0] - 16'(PAL_SAMPLES);
      end else if (w_ff <= WAIT_W'(CHUNK_SAMPLES + 2 * PAL_SAMPLES)) begin
         pre0_c  = OP_WAIT_PAL;
         pre1_c  = OP_WAIT_PAL;
         pre_n_c = 2'd2;
         long_c  = w_ff[15:0] - 16'(2 * PAL_SAMPLES);
      end else begin
         long_c   = 16'(CHUNK_SAMPLES);
         w_next_c = w_ff - WAIT_W'(CHUNK_SAMPLES);
      end
   end

   // Pending wait: loaded by the multiply, stepped by each plan.
   always_comb begin
      w_in = w_ff;
      if (cmd.mul) begin
         w_in = WAIT_W'(gap_ff) * WAIT_W'(FRAME_SAMPLES);
      end else if (cmd.decide) begin
         w_in = w_next_c;
      end
   end

   // Byte counter for the current input beat.
   always_comb begin
      cnt_in = cnt_ff;
      if (cmd.load) begin
         cnt_in = '0;
      end else if (cmd.emit) begin
         cnt_in = cnt_ff + CNT_W'(1);
      end
   end

   // Output byte selection.
   always_comb begin
      unique case (cmd.sel)
         SEL_PRE0:     byte_in = pre0_ff;
         SEL_PRE1:     byte_in = pre1_ff;
         SEL_LONG_OP:  byte_in = OP_WAIT_N;
         SEL_LONG_LO:  byte_in = long_ff[7:0];
         SEL_LONG_HI:  byte_in = long_ff[15:8];
         SEL_WRITE_OP: byte_in = OP_WRITE;
         SEL_ADDR:     byte_in = addr_ff;
         SEL_DATA:     byte_in = data_ff;
         SEL_END_WAIT: byte_in = OP_WAIT_NTSC;
         SEL_END_OP:   byte_in = OP_END;
         default:      byte_in = BYTE_FULL;
      endcase
   end

   assign rsp_valid_in = cmd.emit || (rsp_valid_ff && rsp_stall);

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         cur_frame_ff <= '0;
         clamp_ff     <= 1'b0;
         w_ff         <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cur_frame_ff <= cur_frame_in;
         clamp_ff     <= clamp_in;
         w_ff         <= w_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      gap_ff <= gap_in;
      if (cmd.load) begin
         addr_ff <= req_reg_addr;
         data_ff <= req_reg_data;
      end
      if (cmd.decide) begin
         pre0_ff     <= pre0_c;
         pre1_ff     <= pre1_c;
         pre_n_ff    <= pre_n_c;
         has_long_ff <= has_long_c;
         long_ff     <= long_c;
      end
      if (cmd.emit) begin
         byte_ff    <= byte_in;
         last_ff    <= cmd.last;
         clamped_ff <= clamp_ff;
      end
   end

   // Status to the controller.
   always_comb begin
      sts.out_free  = !rsp_valid_ff || !rsp_stall;
      sts.wait_zero = (w_ff == '0);
      sts.cls_pre_n = pre_n_c;
      sts.pre_n     = pre_n_ff;
      sts.has_long  = has_long_ff;
      sts.cnt_last  = (cnt_ff == CNT_W'(RESULT_LIMIT - 1));
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_byte    = byte_ff;
   assign rsp_last        = last_ff;
   assign rsp_gap_clamped = clamped_ff;

   `VGM_ASSERT(a_clamp_gap, clock, reset, clamp_ff |-> (gap_ff == GAP_W'(MAX_GAP)), "clamped gap is not MAX_GAP")
   `VGM_ASSERT_NEVER(a_cnt_limit, clock, reset, cmd.emit && (cnt_ff >= CNT_W'(RESULT_LIMIT)), "byte beyond the per-beat limit")
   `VGM_ASSERT(a_wait_bound, clock, reset, w_ff <= WAIT_W'(MAX_GAP * FRAME_SAMPLES), "pending wait out of range")

endmodule

`default_nettype wire

/* design/vgm_enc_ctrl.sv */
// ---------------------------------------------------------------------------
// VGM encoder controller
// Sequences one input beat at a time: gap multiply, wait planning, and one
// stream byte per cycle into the datapath output register while it is free.
// ---------------------------------------------------------------------------
`default_nettype none
`include "vgm_wait_and_write_encoder_macros.svh"

module vgm_enc_ctrl (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   input  wire logic                     req_type,
   output      logic                     req_stall,
   input  wire vgm_enc_pkg::enc_sts_type sts,
   output      vgm_enc_pkg::enc_cmd_type cmd
);
   import vgm_enc_pkg::*;

   enc_state_type state_ff, state_in;

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands.
   always_comb begin
      logic          emit_state;
      logic          natural_last;
      enc_state_type nxt;
      enc_state_type after_wait;

      emit_state   = 1'b0;
      natural_last = 1'b0;
      after_wait   = sts.wait_zero ? ST_CMD : ST_DECIDE;
      nxt          = state_ff;
      state_in     = state_ff;
      req_stall    = 1'b1;
      cmd          = '{load: 1'b0, mul: 1'b0, decide: 1'b0, emit: 1'b0,
                       sel: SEL_PRE0, last: 1'b0};

      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = req_type ? ST_END_A : ST_MUL;
            end
         end
         ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            if (sts.wait_zero) begin
               state_in = ST_CMD;
            end else begin
               cmd.decide = 1'b1;
               state_in   = (sts.cls_pre_n != 2'd0) ? ST_PRE0 : ST_LONG_OP;
            end
         end
         ST_PRE0: begin
            emit_state = 1'b1;
            cmd.sel    = SEL_PRE0;
            if (sts.pre_n == 2'd2) begin
               nxt = ST_PRE1;
            end else begin
               nxt = sts.has_long ? ST_LONG_OP : after_wait;
            end
         end
         ST_PRE1: begin
            emit_state = 1'b1;
            cmd.sel    = SEL_PRE1;
            nxt        = sts.has_long ? ST_LONG_OP : after_wait;
         end
         ST_LONG_OP: begin
            emit_state = 1'b1;
            cmd.sel    = SEL_LONG_OP;
            nxt        = ST_LONG_LO;
         end
         ST_LONG_LO: begin
            emit_state = 1'b1;
            cmd.sel    = SEL_LONG_LO;
            nxt        = ST_LONG_HI;
         end
         ST_LONG_HI: begin
            emit_state = 1'b1;
            cmd.sel    = SEL_LONG_HI;
            nxt        = after_wait;
         end
         ST_CMD: begin
            emit_state = 1'b1;
            cmd.sel    = SEL_WRITE_OP;
            nxt        = ST_ADDR;
         end
         ST_ADDR: begin
            emit_state = 1'b1;
            cmd.sel    = SEL_ADDR;
            nxt        = ST_DATA;
         end
         ST_DATA: begin
            emit_state   = 1'b1;
            cmd.sel      = SEL_DATA;
            natural_last = 1'b1;
            nxt          = ST_IDLE;
         end
         ST_END_A: begin
            emit_state = 1'b1;
            cmd.sel    = SEL_END_WAIT;
            nxt        = ST_END_B;
         end
         ST_END_B: begin
            emit_state   = 1'b1;
            cmd.sel      = SEL_END_OP;
            natural_last = 1'b1;
            nxt          = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // A byte state moves on only when the output register can take a byte.
      // Bytes past the per-beat limit are dropped by ending the beat early.
      if (emit_state && sts.out_free) begin
         cmd.emit = 1'b1;
         cmd.last = natural_last || sts.cnt_last;
         state_in = sts.cnt_last ? ST_IDLE : nxt;
      end
   end

   `VGM_ASSERT(a_last_ends, clock, reset, (cmd.emit && cmd.last) |=> (state_ff == ST_IDLE), "last byte did not end the beat")
   `VGM_ASSERT(a_emit_free, clock, reset, cmd.emit |-> sts.out_free, "byte loaded into a held output register")
   `VGM_ASSERT(a_load_next, clock, reset, cmd.load |=> ((state_ff == ST_MUL) || (state_ff == ST_END_A)), "accepted beat not started")

endmodule

`default_nettype wire

/* design/vgm_wait_and_write_encoder.sv */
// ---------------------------------------------------------------------------
// VGM wait-and-write encoder
// A write beat passes the gap multiply and wait planning before its first
// byte reaches rsp; an end request goes straight to its bytes.
// Throughput: one stream byte per cycle from the byte sequencer unless
// rsp_stall holds the output; a new beat is taken only after the previous ends.
// Reset: synchronous; clears the current frame to zero and empties the output.
// ---------------------------------------------------------------------------
`default_nettype none

module vgm_wait_and_write_encoder #(
   parameter int MAX_GAP = vgm_enc_pkg::MAX_GAP_DEFAULT
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output      logic        req_stall,
   input  wire logic        req_type,
   input  wire logic [31:0] req_write_frame,
   input  wire logic [7:0]  req_reg_addr,
   input  wire logic [7:0]  req_reg_data,
   output      logic        rsp_valid,
   input  wire logic        rsp_stall,
   output      logic [7:0]  rsp_out_byte,
   output      logic        rsp_last,
   output      logic        rsp_gap_clamped
);
   import vgm_enc_pkg::*;

   enc_cmd_type cmd;
   enc_sts_type sts;

   // Sequencer.
   vgm_enc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_type  (req_type),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   // Frame tracking, wait planning and output register.
   vgm_enc_dp #(
      .MAX_GAP (MAX_GAP)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .req_write_frame (req_write_frame),
      .req_reg_addr    (req_reg_addr),
      .req_reg_data    (req_reg_data),
      .req_type        (req_type),
      .cmd             (cmd),
      .sts             (sts),
      .rsp_stall       (rsp_stall),
      .rsp_valid       (rsp_valid),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_last        (rsp_last),
      .rsp_gap_clamped (rsp_gap_clamped)
   );

endmodule

`default_nettype wire
